// ===== rtl/core/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared widths, codes and reset constants of the text console engine.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int CMD_W    = 2;
    localparam int CH_W     = 8;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = CH_W + ATTR_W;
    localparam int ROW_IN_W = 5;
    localparam int COL_IN_W = 7;
    localparam int OFFSET_W = 11;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    localparam logic [ATTR_W-1:0] BLANK_ATTR_RESET = 8'h07;
    localparam logic [CH_W-1:0]   NEWLINE_BYTE     = 8'h0A;
    localparam logic [CH_W-1:0]   BLANK_CHAR       = 8'h00;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

endpackage

// ===== rtl/core/tcc_req_if.sv =====
// ----------------------------------------------------------------------------
// tcc_req_if
// Command channel of the text console: valid/ready plus one command item.
// ----------------------------------------------------------------------------
interface tcc_req_if
    import tcc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [CH_W-1:0]     ch;
    logic                end_of_write;
    logic [ROW_IN_W-1:0] read_row;
    logic [COL_IN_W-1:0] read_col;

    modport source (output valid, cmd, ch, end_of_write, read_row, read_col, input ready);
    modport sink   (input valid, cmd, ch, end_of_write, read_row, read_col, output ready);
endinterface

// ===== rtl/core/tcc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tcc_rsp_if
// Result channel of the text console: valid/ready plus one result item.
// ----------------------------------------------------------------------------
interface tcc_rsp_if
    import tcc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] cursor_offset;
    logic                cursor_moved;
    logic [CH_W-1:0]     cell_char;
    logic [ATTR_W-1:0]   cell_attr;
    logic                flush_due;

    modport source (output valid, cursor_offset, cursor_moved, cell_char, cell_attr, flush_due,
                    input ready);
    modport sink   (input valid, cursor_offset, cursor_moved, cell_char, cell_attr, flush_due,
                     output ready);
endinterface

// ===== rtl/core/tcc_ram.sv =====
// ----------------------------------------------------------------------------
// tcc_ram
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module tcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        // read data holds until the next read
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ===== rtl/core/text_console_cursor_scroll_core.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_core
// Text-mode screen engine: cell store, cursor, lazy scroll, clear and read.
// ----------------------------------------------------------------------------
// The screen lives in one single-port RAM of ROWS*COLUMNS cells (attribute in
// the high byte, character in the low byte), addressed through a ring pointer
// to the top row, so a scroll never copies rows. A zero byte, newline, no-op
// or out-of-range read finishes straight from decode; a stored character is read,
// merged and written back on the one RAM port, and a cell read reads the RAM;
// a character or newline that scrolls first blanks the new bottom row one cell
// a cycle and then decodes the item again; a clear sweeps the whole RAM. After
// reset the block blanks the RAM with attribute 0x07 before it accepts its
// first item; blank_attr writes are taken during that pass. A result waiting
// at the output does not stop the next item from being accepted; it only
// holds the end of that item.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_core
    import tcc_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int ROWS    = ROWS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ATTR_W-1:0] cfg_wdata,
    tcc_req_if.sink           req,
    tcc_rsp_if.source         rsp
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int COL_W  = $clog2(COLUMNS);

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_EXEC   = 7'b0000100,
        S_SCROLL = 7'b0001000,
        S_CLEAR  = 7'b0010000,
        S_PUT    = 7'b0100000,
        S_READ   = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [ROW_W-1:0]    top_reg, top_next;
    logic [ADDR_W-1:0]   sweep_reg, sweep_next;
    logic [ATTR_W-1:0]   blank_attr_reg;

    cmd_t                cmd_reg;
    logic [CH_W-1:0]     ch_reg;
    logic                eow_reg;
    logic [ROW_IN_W-1:0] rr_reg;
    logic [COL_IN_W-1:0] rc_reg;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [OFFSET_W-1:0] offset_reg;
    logic                moved_reg;
    logic [CH_W-1:0]     char_reg;
    logic [ATTR_W-1:0]   attr_reg;
    logic                flush_reg;

    logic                accept;
    logic                out_free;
    logic                finish;
    logic                fin_moved;
    logic [CH_W-1:0]     fin_char;
    logic [ATTR_W-1:0]   fin_attr;
    logic [OFFSET_W-1:0] offset_next;

    logic [ROW_W-1:0]    lrow_sel;
    logic [COL_W-1:0]    col_sel;
    logic [ROW_W:0]      row_sum;
    logic [ROW_W-1:0]    phys_row;
    logic [ADDR_W-1:0]   cell_addr;
    logic                read_in_range;

    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_addr;
    logic [CELL_W-1:0]   ram_wdata, ram_rdata;

    tcc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.cursor_offset = offset_reg;
    assign rsp.cursor_moved  = moved_reg;
    assign rsp.cell_char     = char_reg;
    assign rsp.cell_attr     = attr_reg;
    assign rsp.flush_due     = flush_reg;

    assign read_in_range = (32'(rr_reg) < ROWS) && (32'(rc_reg) < COLUMNS);

    // logical row to physical row through the ring pointer
    assign row_sum   = {1'b0, lrow_sel} + {1'b0, top_reg};
    assign phys_row  = (row_sum >= (ROW_W + 1)'(ROWS)) ? ROW_W'(row_sum - (ROW_W + 1)'(ROWS))
                                                        : row_sum[ROW_W-1:0];
    assign cell_addr = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(col_sel);

    assign offset_next = OFFSET_W'(32'(row_next) * COLUMNS + 32'(col_next));

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        top_next   = top_reg;
        sweep_next = sweep_reg;
        finish     = 1'b0;
        fin_moved  = 1'b0;
        fin_char   = BLANK_CHAR;
        fin_attr   = '0;
        lrow_sel   = row_reg;
        col_sel    = col_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_addr   = cell_addr;
        ram_wdata  = {blank_attr_reg, BLANK_CHAR};

        unique case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_addr  = sweep_reg;
                ram_wdata = {BLANK_ATTR_RESET, BLANK_CHAR};
                if (sweep_reg == ADDR_W'(CELLS - 1))
                begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (cmd_reg)
                    CMD_PUT:
                    begin
                        if (ch_reg == BLANK_CHAR)
                        begin
                            finish = out_free;
                        end
                        else if (row_reg == ROW_W'(ROWS))
                        begin
                            // scroll first: blank the row that becomes the bottom
                            sweep_next = '0;
                            state_next = S_SCROLL;
                        end
                        else if (ch_reg == NEWLINE_BYTE)
                        begin
                            finish = out_free;
                            if (out_free)
                            begin
                                row_next = row_reg + 1'b1;
                                col_next = '0;
                            end
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            state_next = S_PUT;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        sweep_next = '0;
                        state_next = S_CLEAR;
                    end
                    CMD_READ:
                    begin
                        lrow_sel = ROW_W'(rr_reg);
                        col_sel  = COL_W'(rc_reg);
                        if (read_in_range)
                        begin
                            ram_re     = 1'b1;
                            state_next = S_READ;
                        end
                        else
                        begin
                            finish = out_free;
                        end
                    end
                    default:
                    begin
                        finish = out_free;
                    end
                endcase
            end
            S_SCROLL:
            begin
                lrow_sel = '0;
                col_sel  = sweep_reg[COL_W-1:0];
                ram_we   = 1'b1;
                if (sweep_reg == ADDR_W'(COLUMNS - 1))
                begin
                    top_next   = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;
                    row_next   = ROW_W'(ROWS - 1);
                    state_next = S_EXEC;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            S_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = sweep_reg;
                if (sweep_reg == ADDR_W'(CELLS - 1))
                begin
                    // hold on the last cell until the result slot frees up
                    finish = out_free;
                    if (out_free)
                    begin
                        top_next = '0;
                        row_next = '0;
                        col_next = '0;
                    end
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            S_PUT:
            begin
                if (out_free)
                begin
                    finish    = 1'b1;
                    fin_moved = 1'b1;
                    ram_we    = 1'b1;
                    ram_wdata = {ram_rdata[CELL_W-1:CH_W], ch_reg};
                    if (col_reg == COL_W'(COLUMNS - 1))
                    begin
                        col_next = '0;
                        row_next = row_reg + 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    finish   = 1'b1;
                    fin_char = ram_rdata[CH_W-1:0];
                    fin_attr = ram_rdata[CELL_W-1:CH_W];
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase

        if (finish)
        begin
            state_next = S_IDLE;
        end
    end

    always_comb
    begin
        if (finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            col_reg        <= '0;
            row_reg        <= '0;
            top_reg        <= '0;
            sweep_reg      <= '0;
            blank_attr_reg <= BLANK_ATTR_RESET;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            top_reg       <= top_next;
            sweep_reg     <= sweep_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                blank_attr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(req.cmd);
            ch_reg  <= req.ch;
            eow_reg <= req.end_of_write;
            rr_reg  <= req.read_row;
            rc_reg  <= req.read_col;
        end
        if (finish)
        begin
            offset_reg <= offset_next;
            moved_reg  <= fin_moved;
            char_reg   <= fin_char;
            attr_reg   <= fin_attr;
            flush_reg  <= (cmd_reg == CMD_PUT) && eow_reg;
        end
    end

    // cursor row may sit one past the bottom while a scroll is pending
    assert property (@(posedge clk) disable iff (!rst_n) 32'(row_reg) <= ROWS)
        else $error("cursor row beyond pending-scroll position");

    assert property (@(posedge clk) disable iff (!rst_n) 32'(top_reg) < ROWS)
        else $error("ring top pointer out of range");

    assert property (@(posedge clk) disable iff (!rst_n) (state_reg == S_IDLE) |-> !ram_we)
        else $error("screen written with no item in flight");

    assert property (@(posedge clk) disable iff (!rst_n) accept |=> (state_reg == S_EXEC))
        else $error("accepted item not taken into execution");

    assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (rsp_valid_reg && (state_reg == S_IDLE)))
        else $error("finished item did not reach the result register");

endmodule
